>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; the bodies are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: label");
// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

>>> src/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Sizes, character codes and word types of the terminal line discipline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tld_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int LINE_LEN   = 128;
  localparam int MAX_READ   = 64;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int LEN_W = $clog2(LINE_LEN);
  localparam int RD_W  = $clog2(MAX_READ + 1);

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_DEL   = 8'd127;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] key_char;
    logic [6:0] max_bytes;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       data_valid;
    logic       last;
  } out_word_t;

endpackage

>>> src/tld_ram.sv
// ----------------------------------------------------------------------------
// tld_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tty_line_discipline.sv
// ----------------------------------------------------------------------------
// tty_line_discipline
// Terminal input line discipline: line editing, commit into a byte ring
// FIFO, and multi-byte reads, run by a small sequencer over two RAMs.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   start, cmd, busy                        start high while busy low
//  result    result, result_strobe                   one-cycle strobe per word, no stall
//  config    cfg_write_en, cfg_write_data            write on enable, no wait
//
// A newline key with room in the line store commits the line, alternating
// S_COMMIT_RD and S_COMMIT_WR per byte and ending with the newline write,
// set by the registered read of the line store feeding the FIFO write port.
// A read pops one byte per cycle in S_READ; each result word appears
// in the cycle after its FIFO read is issued. Reset is synchronous, clears
// pointers and counts and selects canonical mode; both stores stay unset.
// The receiver cannot stall, so result words are never held back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tty_line_discipline (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tld_pkg::in_word_t  cmd,
  output logic               busy,
  output tld_pkg::out_word_t result,
  output logic               result_strobe,
  input  logic               cfg_write_en,
  input  logic               cfg_write_data
);

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_COMMIT_RD = 4'b0010,
    S_COMMIT_WR = 4'b0100,
    S_READ      = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [tld_pkg::PTR_W-1:0] write_pointer, write_pointer_next;
  logic [tld_pkg::PTR_W-1:0] read_pointer, read_pointer_next;
  logic [tld_pkg::CNT_W-1:0] fill_count, fill_count_next;
  logic [tld_pkg::LEN_W-1:0] line_length, line_length_next;
  logic [tld_pkg::LEN_W-1:0] line_index, line_index_next;
  logic [tld_pkg::RD_W-1:0]  remaining, remaining_next;
  logic                      canonical_mode;
  logic                      byte_pend, byte_pend_next;
  logic                      byte_last, byte_last_next;
  logic                      empty_pend, empty_pend_next;

  logic                      fifo_we;
  logic [7:0]                fifo_wdata;
  logic [7:0]                fifo_rdata;
  logic                      line_we;
  logic [7:0]                line_rdata;

  logic                      accept;
  logic                      fifo_full;
  logic                      line_room;
  logic                      is_newline;
  logic                      is_backspace;
  logic                      is_printable;
  logic [tld_pkg::RD_W-1:0]  want;

  tld_ram #(
    .WIDTH(8),
    .DEPTH(tld_pkg::FIFO_DEPTH)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (fifo_we),
    .waddr(write_pointer),
    .wdata(fifo_wdata),
    .raddr(read_pointer),
    .rdata(fifo_rdata)
  );

  tld_ram #(
    .WIDTH(8),
    .DEPTH(tld_pkg::LINE_LEN)
  ) u_line_ram (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_length),
    .wdata(cmd.key_char),
    .raddr(line_index),
    .rdata(line_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign fifo_full    = (fill_count >= tld_pkg::CNT_W'(tld_pkg::FIFO_DEPTH - 1));
  assign line_room    = (line_length < tld_pkg::LEN_W'(tld_pkg::LINE_LEN - 1));
  assign is_newline   = (cmd.key_char == tld_pkg::CHAR_LF) ||
                        (cmd.key_char == tld_pkg::CHAR_CR);
  assign is_backspace = (cmd.key_char == tld_pkg::CHAR_BS) ||
                        (cmd.key_char == tld_pkg::CHAR_DEL);
  assign is_printable = (cmd.key_char >= tld_pkg::CHAR_SPACE) &&
                        (cmd.key_char < tld_pkg::CHAR_DEL);
  assign want = (cmd.max_bytes > 7'(tld_pkg::MAX_READ)) ?
                tld_pkg::RD_W'(tld_pkg::MAX_READ) : cmd.max_bytes[tld_pkg::RD_W-1:0];

  // Editing only writes the line store from an accepted key word.
  assign line_we = accept && (cmd.operation == tld_pkg::OP_KEY) && !fifo_full &&
                   canonical_mode && is_printable && line_room;

  always_comb begin
    state_next         = state;
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    fill_count_next    = fill_count;
    line_length_next   = line_length;
    line_index_next    = line_index;
    remaining_next     = remaining;
    byte_pend_next     = 1'b0;
    byte_last_next     = byte_last;
    empty_pend_next    = 1'b0;
    fifo_we            = 1'b0;
    fifo_wdata         = cmd.key_char;

    case (state)
      S_IDLE: begin
        if (accept && cmd.operation == tld_pkg::OP_KEY) begin
          if (!fifo_full) begin
            if (!canonical_mode) begin
              fifo_we = 1'b1;
            end else if (is_newline) begin
              if (line_room) begin
                line_index_next = '0;
                state_next      = S_COMMIT_RD;
              end
            end else if (is_backspace) begin
              if (line_length != '0) begin
                line_length_next = line_length - 1'b1;
              end
            end else if (is_printable && line_room) begin
              line_length_next = line_length + 1'b1;
            end
          end
        end else if (accept) begin
          if (want == '0 || fill_count == '0) begin
            empty_pend_next = 1'b1;
          end else begin
            remaining_next = want;
            state_next     = S_READ;
          end
        end
      end

      S_COMMIT_RD: begin
        if (line_index < line_length && !fifo_full) begin
          state_next = S_COMMIT_WR;
        end else begin
          if (!fifo_full) begin
            fifo_we    = 1'b1;
            fifo_wdata = tld_pkg::CHAR_LF;
          end
          line_length_next = '0;
          state_next       = S_IDLE;
        end
      end

      S_COMMIT_WR: begin
        fifo_we         = 1'b1;
        fifo_wdata      = line_rdata;
        line_index_next = line_index + 1'b1;
        state_next      = S_COMMIT_RD;
      end

      S_READ: begin
        // The RAM latches the byte at read_pointer now; it is shown next cycle.
        byte_pend_next    = 1'b1;
        byte_last_next    = (remaining == tld_pkg::RD_W'(1)) ||
                            (fill_count == tld_pkg::CNT_W'(1));
        read_pointer_next = (read_pointer == tld_pkg::PTR_W'(tld_pkg::FIFO_DEPTH - 1)) ?
                            '0 : read_pointer + 1'b1;
        fill_count_next   = fill_count - 1'b1;
        remaining_next    = remaining - 1'b1;
        if (byte_last_next) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fifo_we) begin
      write_pointer_next = (write_pointer == tld_pkg::PTR_W'(tld_pkg::FIFO_DEPTH - 1)) ?
                           '0 : write_pointer + 1'b1;
      fill_count_next    = fill_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      write_pointer  <= '0;
      read_pointer   <= '0;
      fill_count     <= '0;
      line_length    <= '0;
      line_index     <= '0;
      remaining      <= '0;
      canonical_mode <= 1'b1;
      byte_pend      <= 1'b0;
      byte_last      <= 1'b0;
      empty_pend     <= 1'b0;
    end else begin
      state         <= state_next;
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      fill_count    <= fill_count_next;
      line_length   <= line_length_next;
      line_index    <= line_index_next;
      remaining     <= remaining_next;
      byte_pend     <= byte_pend_next;
      byte_last     <= byte_last_next;
      empty_pend    <= empty_pend_next;
      if (cfg_write_en) begin
        canonical_mode <= cfg_write_data;
      end
    end
  end

  assign result_strobe     = byte_pend || empty_pend;
  assign result.read_data  = byte_pend ? fifo_rdata : 8'd0;
  assign result.data_valid = byte_pend;
  assign result.last       = byte_pend ? byte_last : 1'b1;

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= tld_pkg::CNT_W'(tld_pkg::FIFO_DEPTH - 1))
  `ASSERT_ALWAYS(a_line_bound, clk, rst, line_length <= tld_pkg::LEN_W'(tld_pkg::LINE_LEN - 1))
  `ASSERT_IMPLY(a_byte_from_read, clk, rst, result_strobe && result.data_valid, $past(state == S_READ))
  `ASSERT_IMPLY(a_single_source, clk, rst, result_strobe, !(byte_pend && empty_pend))

endmodule

>>> sim/tb_tty_line_discipline.sv
// ----------------------------------------------------------------------------
// tb_tty_line_discipline
// Self-checking bench for the terminal line discipline. A behavioral model of
// the line store and byte ring predicts every read result word. Result words
// are checked in order as they are strobed out. The run covers directed
// editing, raw and read cases, then stores driven full and random line
// traffic in both modes, with random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tty_line_discipline;
  import tld_pkg::*;

  localparam int     SETTLE_CYCLES = 2 * LINE_LEN + 2 * MAX_READ + 16;
  localparam longint TIMEOUT_NS    = 10_000_000;

  logic      clk;
  logic      rst;
  logic      start;
  in_word_t  cmd;
  logic      busy;
  out_word_t result;
  logic      result_strobe;
  logic      cfg_write_en;
  logic      cfg_write_data;

  tty_line_discipline dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .cmd            (cmd),
    .busy           (busy),
    .result         (result),
    .result_strobe  (result_strobe),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // Model state of the byte ring, the line store and the mode register.
  logic [7:0]       ring_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] ring_wr;
  logic [PTR_W-1:0] ring_rd;
  logic [CNT_W-1:0] ring_count;
  logic [7:0]       line_mem [LINE_LEN];
  logic [LEN_W-1:0] line_len;
  logic             canon_mode;

  out_word_t read_bytes_q[$];

  int  error_count;
  int  words_sent;
  int  reads_sent;
  int  results_checked;
  bit  idle_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic bit ring_full();
    return ring_count >= CNT_W'(FIFO_DEPTH - 1);
  endfunction

  function automatic void ring_push(logic [7:0] b);
    ring_mem[ring_wr] = b;
    ring_wr = PTR_W'((int'(ring_wr) + 1) % FIFO_DEPTH);
    ring_count = ring_count + 1'b1;
  endfunction

  // Applies one accepted word to the model and queues the read results.
  function automatic void predict_word(in_word_t w);
    int        i;
    int        want;
    int        n;
    out_word_t r;
    if (w.operation == OP_KEY) begin
      if (!ring_full()) begin
        if (!canon_mode) begin
          ring_push(w.key_char);
        end else if (w.key_char == CHAR_LF || w.key_char == CHAR_CR) begin
          if (line_len < LEN_W'(LINE_LEN - 1)) begin
            for (i = 0; i < int'(line_len) && !ring_full(); i++) begin
              ring_push(line_mem[i]);
            end
            if (!ring_full()) begin
              ring_push(CHAR_LF);
            end
            line_len = '0;
          end
        end else if (w.key_char == CHAR_BS || w.key_char == CHAR_DEL) begin
          if (line_len != '0) begin
            line_len = line_len - 1'b1;
          end
        end else if (w.key_char >= CHAR_SPACE && w.key_char < CHAR_DEL) begin
          if (line_len < LEN_W'(LINE_LEN - 1)) begin
            line_mem[line_len] = w.key_char;
            line_len = line_len + 1'b1;
          end
        end
      end
    end else begin
      want = (int'(w.max_bytes) > MAX_READ) ? MAX_READ : int'(w.max_bytes);
      n = 0;
      while (n < want && ring_count != '0) begin
        r.read_data  = ring_mem[ring_rd];
        r.data_valid = 1'b1;
        ring_rd = PTR_W'((int'(ring_rd) + 1) % FIFO_DEPTH);
        ring_count = ring_count - 1'b1;
        n++;
        r.last = (n == want || ring_count == '0);
        read_bytes_q.push_back(r);
      end
      if (n == 0) begin
        r.read_data  = 8'd0;
        r.data_valid = 1'b0;
        r.last       = 1'b1;
        read_bytes_q.push_back(r);
      end
    end
  endfunction

  // Called at a clock edge; returns at the edge that accepts the word.
  // The start line is left high so that a following word goes out back to back.
  task automatic send_word(in_word_t w);
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    predict_word(w);
    words_sent++;
  endtask

  task automatic send_key(logic [7:0] c);
    in_word_t w;
    w.operation = OP_KEY;
    w.key_char  = c;
    w.max_bytes = 7'($urandom);
    send_word(w);
  endtask

  task automatic send_read(logic [6:0] n);
    in_word_t w;
    w.operation = OP_READ;
    w.key_char  = 8'($urandom);
    w.max_bytes = n;
    send_word(w);
    reads_sent++;
  endtask

  function automatic logic [6:0] pick_read_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return 7'd0;
    end else if (roll < 25) begin
      return 7'($urandom_range(64, 127));
    end
    return 7'($urandom_range(1, 24));
  endfunction

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (read_bytes_q.size() != 0);
  endtask

  // A key word gives no result, so a commit may still be running after the
  // last result word; the settle pause covers the longest commit.
  task automatic set_mode(logic mode);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mode;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    canon_mode = mode;
  endtask

  task automatic run_random_lines(int target);
    int first;
    int len;
    int k;
    int roll;
    first = words_sent;
    while (words_sent - first < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(110, 135) : $urandom_range(0, 16);
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          send_key(8'($urandom_range(32, 126)));
        end else if (roll < 92) begin
          send_key(roll[0] ? CHAR_BS : CHAR_DEL);
        end else begin
          send_key(8'($urandom_range(0, 255)));
        end
        sender_gap();
      end
      // Now and then the newline is left out, so the next line runs on.
      if ($urandom_range(0, 9) != 0) begin
        send_key($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        sender_gap();
      end
      if ($urandom_range(0, 9) < 7) begin
        send_read(pick_read_size());
        sender_gap();
      end
      if (idle_on && $urandom_range(0, 9) == 0) begin
        drain_results();
      end
    end
  endtask

  task automatic test_empty_reads();
    send_read(7'd0);
    sender_gap();
    send_read(7'd64);
    sender_gap();
    send_read(7'd127);
    sender_gap();
  endtask

  task automatic test_canonical_editing();
    send_key(CHAR_BS);
    send_key(CHAR_SPACE);
    send_key(8'd126);
    sender_gap();
    send_key(CHAR_DEL);
    send_key(8'd126);
    send_key(8'd65);
    send_key(CHAR_BS);
    send_key(8'd0);
    sender_gap();
    send_key(8'd31);
    send_key(8'd128);
    send_key(8'd255);
    send_key(CHAR_CR);
    sender_gap();
    send_key(CHAR_LF);
    send_read(7'd1);
    sender_gap();
    send_read(7'd127);
    sender_gap();
  endtask

  task automatic test_raw_passthrough();
    set_mode(1'b0);
    send_key(8'd0);
    send_key(8'd255);
    send_key(CHAR_CR);
    sender_gap();
    send_key(CHAR_BS);
    send_key(CHAR_DEL);
    send_key(CHAR_LF);
    send_read(7'd3);
    sender_gap();
    send_read(7'd64);
    send_read(7'd0);
    sender_gap();
  endtask

  // Fills the line store past its limit, then fills the ring until a commit
  // is cut short, then checks that key words are dropped in both modes.
  task automatic test_full_stores();
    set_mode(1'b1);
    repeat (LINE_LEN + 2) begin
      send_key(8'($urandom_range(32, 126)));
      sender_gap();
    end
    send_key(CHAR_CR);
    send_key(CHAR_BS);
    send_key(CHAR_LF);
    sender_gap();
    repeat (LINE_LEN - 2) begin
      send_key(8'($urandom_range(32, 126)));
      sender_gap();
    end
    send_key(CHAR_CR);
    repeat (5) begin
      send_key(8'($urandom_range(32, 126)));
      sender_gap();
    end
    send_key(CHAR_LF);
    repeat (3) begin
      send_key(8'($urandom_range(32, 126)));
    end
    send_key(CHAR_BS);
    send_key(CHAR_CR);
    sender_gap();
    set_mode(1'b0);
    repeat (4) begin
      send_key(8'($urandom_range(0, 255)));
    end
    send_read(7'd4);
    sender_gap();
    repeat (6) begin
      send_key(8'($urandom_range(0, 255)));
      sender_gap();
    end
  endtask

  task automatic test_random_raw();
    int k;
    for (k = 0; k < 50; k++) begin
      if ($urandom_range(0, 9) < 6) begin
        send_key(8'($urandom_range(0, 255)));
      end else begin
        send_read(pick_read_size());
      end
      if ($urandom_range(0, 19) == 0) begin
        drain_results();
      end else begin
        sender_gap();
      end
    end
  endtask

  task automatic test_random_lines();
    set_mode(1'b1);
    run_random_lines(50);
  endtask

  task automatic test_back_to_back();
    drain_results();
    idle_on = 1'b0;
    run_random_lines(40);
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && result_strobe) begin
      if (read_bytes_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", result));
      end else begin
        want = read_bytes_q.pop_front();
        results_checked++;
        if (result.read_data !== want.read_data) begin
          report_mismatch($sformatf("read_data %h, expected %h",
                                    result.read_data, want.read_data));
        end
        if (result.data_valid !== want.data_valid) begin
          report_mismatch($sformatf("data_valid %b, expected %b",
                                    result.data_valid, want.data_valid));
        end
        if (result.last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b", result.last, want.last));
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    cfg_write_en   = 1'b0;
    cfg_write_data = 1'b0;
    ring_wr        = '0;
    ring_rd        = '0;
    ring_count     = '0;
    line_len       = '0;
    canon_mode     = 1'b1;
    idle_on        = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_reads();
    test_canonical_editing();
    test_raw_passthrough();
    test_full_stores();
    test_random_raw();
    test_random_lines();
    test_back_to_back();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d reads); checked %0d result words.",
             words_sent, reads_sent, results_checked);
    $display("Covered editing, raw and canonical modes, full line and ring, long reads.");
    if (error_count == 0) begin
      $display("tb_tty_line_discipline passed");
    end else begin
      $display("tb_tty_line_discipline failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_tty_line_discipline failed");
    $finish;
  end

endmodule
